// ===== design/fcw_pkg.sv =====
// Shared types and constants for the FAT12 cluster chain walker.
package fcw_pkg;

    localparam int TABLE_BYTES  = 6144;
    localparam int EVEN_DEPTH   = (TABLE_BYTES + 1) / 2;
    localparam int ODD_DEPTH    = TABLE_BYTES / 2;
    localparam int BANK_AW      = $clog2(EVEN_DEPTH);

    localparam int ACTION_W     = 2;
    localparam int BYTE_INDEX_W = 13;
    localparam int BYTE_W       = 8;
    localparam int CLUSTER_W    = 12;
    localparam int LBA_W        = 20;
    localparam int DSTART_W     = 16;
    localparam int SPC_W        = 8;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STEP  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_START = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPC        = 1'b1;

    localparam logic [CLUSTER_W-1:0] END_MARK           = 12'hFF8;
    localparam logic [CLUSTER_W-1:0] FIRST_DATA_CLUSTER = 12'd2;
    localparam logic [DSTART_W-1:0]  DSTART_RESET       = 16'd33;
    localparam logic [SPC_W-1:0]     SPC_RESET          = 8'd1;

    typedef struct packed {
        logic                    rd_en;
        logic [CLUSTER_W-1:0]    rd_cluster;
        logic                    wr_en;
        logic [BYTE_INDEX_W-1:0] wr_index;
        logic [BYTE_W-1:0]       wr_data;
    } t_fetch_req;

endpackage

// ===== design/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker: control, config and result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  input   | in        | i_valid / o_ready       | action, byte_index, byte_value, start_cluster
//  result  | out       | o_valid / i_ready       | cluster, sector_lba, next_cluster, flags
//  config  | in        | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
//  A load request writes one byte into the table banks. A start or step request reads
//  the table banks, then assembles the entry and loads the result register.
//  The next request is taken while the previous result still waits at the output.
//  If the result register is still full and i_ready is low, the walk holds in its read state.
//  Reset is synchronous, active low; table contents are not cleared.
module fat12_cluster_chain_walker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [fcw_pkg::ACTION_W-1:0]     i_action,
    input  logic [fcw_pkg::BYTE_INDEX_W-1:0] i_byte_index,
    input  logic [fcw_pkg::BYTE_W-1:0]       i_byte_value,
    input  logic [fcw_pkg::CLUSTER_W-1:0]    i_start_cluster,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fcw_pkg::CLUSTER_W-1:0]    o_cluster,
    output logic [fcw_pkg::LBA_W-1:0]        o_sector_lba,
    output logic [fcw_pkg::CLUSTER_W-1:0]    o_next_cluster,
    output logic                             o_end_of_chain,
    output logic                             o_bad_cluster,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fcw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [fcw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fcw_pkg::*;

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                r_state, n_state;
    logic [CLUSTER_W-1:0]  r_following, n_following;
    logic [CLUSTER_W-1:0]  r_cur, n_cur;
    logic [LBA_W-1:0]      r_prod, n_prod;
    logic [DSTART_W-1:0]   r_dstart, n_dstart;
    logic [SPC_W-1:0]      r_spc, n_spc;
    logic                  r_out_valid, n_out_valid;
    logic [CLUSTER_W-1:0]  r_out_cluster, n_out_cluster;
    logic [LBA_W-1:0]      r_out_lba, n_out_lba;
    logic [CLUSTER_W-1:0]  r_out_next, n_out_next;
    logic                  r_out_eoc, n_out_eoc;
    logic                  r_out_bad, n_out_bad;

    t_fetch_req            w_req;
    logic [CLUSTER_W-1:0]  w_entry;
    logic                  w_accept;
    logic [CLUSTER_W-1:0]  w_visit;
    logic [LBA_W-1:0]      w_diff;
    logic [LBA_W+SPC_W-1:0] w_mult;

    assign w_accept = i_valid && o_ready;
    assign w_visit  = (i_action == ACT_START) ? i_start_cluster : r_following;
    assign w_diff   = {{(LBA_W-CLUSTER_W){1'b0}}, w_visit}
                    - {{(LBA_W-CLUSTER_W){1'b0}}, FIRST_DATA_CLUSTER};
    assign w_mult   = w_diff * r_spc;

    fcw_fetch u_fetch (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_entry (w_entry)
    );

    always_comb begin
        n_state       = r_state;
        n_following   = r_following;
        n_cur         = r_cur;
        n_prod        = r_prod;
        n_dstart      = r_dstart;
        n_spc         = r_spc;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_cluster = r_out_cluster;
        n_out_lba     = r_out_lba;
        n_out_next    = r_out_next;
        n_out_eoc     = r_out_eoc;
        n_out_bad     = r_out_bad;

        w_req            = '0;
        w_req.rd_cluster = w_visit;
        w_req.wr_index   = i_byte_index;
        w_req.wr_data    = i_byte_value;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DATA_START: n_dstart = i_cfg_data;
                CFG_SPC:        n_spc    = i_cfg_data[SPC_W-1:0];
                default:        n_dstart = r_dstart;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_action)
                        ACT_LOAD: begin
                            w_req.wr_en = 1'b1;
                        end
                        ACT_START, ACT_STEP: begin
                            w_req.rd_en = 1'b1;
                            n_cur       = w_visit;
                            n_prod      = w_mult[LBA_W-1:0];
                            n_state     = S_READ;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (!r_out_valid || i_ready) begin
                    n_following   = w_entry;
                    n_out_valid   = 1'b1;
                    n_out_cluster = r_cur;
                    n_out_lba     = {{(LBA_W-DSTART_W){1'b0}}, r_dstart} + r_prod;
                    n_out_next    = w_entry;
                    n_out_eoc     = w_entry >= END_MARK;
                    n_out_bad     = r_cur < FIRST_DATA_CLUSTER;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_following <= '0;
            r_cur       <= '0;
            r_dstart    <= DSTART_RESET;
            r_spc       <= SPC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_following <= n_following;
            r_cur       <= n_cur;
            r_dstart    <= n_dstart;
            r_spc       <= n_spc;
            r_out_valid <= n_out_valid;
        end
        r_prod        <= n_prod;
        r_out_cluster <= n_out_cluster;
        r_out_lba     <= n_out_lba;
        r_out_next    <= n_out_next;
        r_out_eoc     <= n_out_eoc;
        r_out_bad     <= n_out_bad;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_cluster      = r_out_cluster;
    assign o_sector_lba   = r_out_lba;
    assign o_next_cluster = r_out_next;
    assign o_end_of_chain = r_out_eoc;
    assign o_bad_cluster  = r_out_bad;
endmodule

// ===== design/fcw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fcw_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== design/fcw_fetch.sv =====
// Table storage in even/odd byte banks and 12-bit entry assembly.
module fcw_fetch (
    input  logic                         i_clk,
    input  fcw_pkg::t_fetch_req          i_req,
    output logic [fcw_pkg::CLUSTER_W-1:0] o_entry
);
    import fcw_pkg::*;

    logic [BYTE_INDEX_W:0]   w_triple;
    logic [BYTE_INDEX_W-1:0] w_pos;
    logic [BYTE_INDEX_W:0]   w_pos1;
    logic                    w_lo_ok;
    logic                    w_hi_ok;
    logic                    w_wr_ok;
    logic [BANK_AW-1:0]      w_even_rd_addr;
    logic [BANK_AW-1:0]      w_odd_rd_addr;
    logic [BANK_AW-1:0]      w_wr_addr;
    logic [BYTE_W-1:0]       w_even_data;
    logic [BYTE_W-1:0]       w_odd_data;
    logic [BYTE_W-1:0]       w_lo;
    logic [BYTE_W-1:0]       w_hi;
    logic [2*BYTE_W-1:0]     w_word;

    logic r_pos_odd;
    logic r_clus_odd;
    logic r_lo_ok;
    logic r_hi_ok;

    // byte position of the entry: (cluster * 3) / 2
    assign w_triple = {1'b0, i_req.rd_cluster, 1'b0} + {2'b00, i_req.rd_cluster};
    assign w_pos    = w_triple[BYTE_INDEX_W:1];
    assign w_pos1   = {1'b0, w_pos} + {{BYTE_INDEX_W{1'b0}}, 1'b1};
    assign w_lo_ok  = {1'b0, w_pos} < (BYTE_INDEX_W+1)'(TABLE_BYTES);
    assign w_hi_ok  = w_pos1 < (BYTE_INDEX_W+1)'(TABLE_BYTES);

    assign w_even_rd_addr = w_pos1[BANK_AW:1];
    assign w_odd_rd_addr  = w_pos[BANK_AW:1];

    assign w_wr_ok   = i_req.wr_en
                     && ({1'b0, i_req.wr_index} < (BYTE_INDEX_W+1)'(TABLE_BYTES));
    assign w_wr_addr = i_req.wr_index[BANK_AW:1];

    fcw_ram #(
        .DEPTH (EVEN_DEPTH),
        .WIDTH (BYTE_W)
    ) u_even_bank (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_ok && !i_req.wr_index[0]),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_req.wr_data),
        .i_rd_en   (i_req.rd_en),
        .i_rd_addr (w_even_rd_addr),
        .o_rd_data (w_even_data)
    );

    fcw_ram #(
        .DEPTH (ODD_DEPTH),
        .WIDTH (BYTE_W)
    ) u_odd_bank (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_ok && i_req.wr_index[0]),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_req.wr_data),
        .i_rd_en   (i_req.rd_en),
        .i_rd_addr (w_odd_rd_addr),
        .o_rd_data (w_odd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_pos_odd  <= w_pos[0];
            r_clus_odd <= i_req.rd_cluster[0];
            r_lo_ok    <= w_lo_ok;
            r_hi_ok    <= w_hi_ok;
        end
    end

    assign w_lo   = !r_lo_ok ? '0 : (r_pos_odd ? w_odd_data : w_even_data);
    assign w_hi   = !r_hi_ok ? '0 : (r_pos_odd ? w_even_data : w_odd_data);
    assign w_word = {w_hi, w_lo};

    assign o_entry = r_clus_odd ? w_word[2*BYTE_W-1:4] : w_word[CLUSTER_W-1:0];
endmodule

// ===== design/fcw_checker.sv =====
// Port-level assertions for the FAT12 cluster chain walker, with bind.
module fcw_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  logic [fcw_pkg::ACTION_W-1:0]     i_action,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  logic [fcw_pkg::CLUSTER_W-1:0]    o_cluster,
    input  logic [fcw_pkg::LBA_W-1:0]        o_sector_lba,
    input  logic [fcw_pkg::CLUSTER_W-1:0]    o_next_cluster,
    input  logic                             o_end_of_chain,
    input  logic                             o_bad_cluster
);
    import fcw_pkg::*;

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cluster) && $stable(o_sector_lba)
                                && $stable(o_next_cluster))
        else $error("result changed while stalled");

    a_eoc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_end_of_chain == (o_next_cluster >= END_MARK)))
        else $error("end of chain flag mismatch");

    a_bad_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bad_cluster == (o_cluster < FIRST_DATA_CLUSTER)))
        else $error("bad cluster flag mismatch");

    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_action == ACT_START || i_action == ACT_STEP)
        |=> !o_ready)
        else $error("walk request did not occupy the table read");

endmodule

bind fat12_cluster_chain_walker fcw_checker u_fcw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_action       (i_action),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_cluster      (o_cluster),
    .o_sector_lba   (o_sector_lba),
    .o_next_cluster (o_next_cluster),
    .o_end_of_chain (o_end_of_chain),
    .o_bad_cluster  (o_bad_cluster)
);
